/* rtl/hpte_pkg.sv */
// Shared types and constants for the hashed page table engine.
package hpte_pkg;

  // Group geometry: fixed eight-way groups
  localparam int unsigned WAYS     = 8;
  localparam int unsigned WAY_BITS = 3;

  // Field widths of one stored translation entry
  localparam int unsigned VSID_BITS = 24;
  localparam int unsigned API_BITS  = 6;
  localparam int unsigned RPN_BITS  = 20;
  localparam int unsigned WIMG_BITS = 4;
  localparam int unsigned PP_BITS   = 2;
  localparam int unsigned CNT_BITS  = 4;

  // Command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // One translation entry, 57 bits
  typedef struct packed {
    logic [VSID_BITS-1:0] vsid;
    logic                 h;
    logic [API_BITS-1:0]  api;
    logic [RPN_BITS-1:0]  rpn;
    logic [WIMG_BITS-1:0] wimg;
    logic [PP_BITS-1:0]   pp;
  } entry_t;

  // Result of comparing one group against the request
  typedef struct packed {
    logic [WAYS-1:0]     match;
    logic                hit;
    logic [RPN_BITS-1:0] hit_rpn;
    logic                free;
    logic [WAY_BITS-1:0] free_way;
    logic [CNT_BITS-1:0] count;
  } cmp_res_t;

endpackage

/* rtl/hpte_cmp.sv */
// Group compare unit: match, first hit, first free way and match count of one group.
module hpte_cmp
  import hpte_pkg::*;
(
  input  logic [WAYS-1:0]      valid_i,
  input  entry_t               row_i [WAYS],
  input  logic [API_BITS-1:0]  api_i,
  input  logic [VSID_BITS-1:0] vsid_i,
  output cmp_res_t             res_o
);

  always_comb begin
    cmp_res_t r;
    r = '0;
    // per-way tag compare
    for (int w = 0; w < WAYS; w++) begin
      r.match[w] = valid_i[w] && (row_i[w].api == api_i) && (row_i[w].vsid == vsid_i);
    end
    // priority pick, lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (r.match[w]) begin
        r.hit     = 1'b1;
        r.hit_rpn = row_i[w].rpn;
      end
      if (!valid_i[w]) begin
        r.free     = 1'b1;
        r.free_way = WAY_BITS'(w);
      end
    end
    // number of matching ways
    for (int w = 0; w < WAYS; w++) begin
      r.count = r.count + {{(CNT_BITS-1){1'b0}}, r.match[w]};
    end
    res_o = r;
  end

endmodule

/* rtl/hashed_page_table_engine_core.sv */
// Top level of the hashed page table engine: sequencer, group memories, result register.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o) carries one command beat: insert,
//   remove or look up, with the effective address, segment id, physical
//   address and wimg attributes.
// - Output channel (out_valid_o/out_ready_i) returns one result beat per
//   command; fields not belonging to the command are 0.
// - The primary group is read at the accepting edge, compared (and written
//   back) in the primary step while the secondary group is read, and in
//   the secondary step the secondary group is compared and written back
//   and the result register is loaded. Both steps share the one group
//   compare unit; in_ready_o returns high only once the result is loaded,
//   so a new beat is not accepted before the previous one is finished.
// - After reset the valid memory is cleared one group per cycle, through all
//   2**GROUP_INDEX_BITS groups; in_ready_o stays low meanwhile.
// - A finished result waits in the output register; a new beat is accepted
//   while it waits, and the engine holds in its last step if the previous
//   result has still not been taken.
module hashed_page_table_engine_core
  import hpte_pkg::*;
#(
  parameter int unsigned GROUP_INDEX_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] effective_address_i,
  input  logic [23:0] segment_id_i,
  input  logic [31:0] physical_address_i,
  input  logic        write_through_i,
  input  logic        cache_disable_i,
  input  logic        memory_coherent_i,
  input  logic        guarded_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [31:0] mapped_address_o,
  output logic [4:0]  removed_count_o,
  output logic        tlb_invalidate_o,
  output logic        placed_secondary_o,
  output logic        evicted_o
);

  localparam int unsigned GROUP_COUNT = 1 << GROUP_INDEX_BITS;
  localparam int unsigned GB          = GROUP_INDEX_BITS;

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_PRI  = 4'b0100,
    S_SEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [GB-1:0] clr_cnt_q, clr_cnt_d;

  // Group memories
  logic [WAYS-1:0] vmem [GROUP_COUNT];
  entry_t          smem [GROUP_COUNT][WAYS];
  logic [WAYS-1:0] vrow_q;
  entry_t          srow_q [WAYS];

  // Request registers
  cmd_e                 cmd_q;
  logic [GB-1:0]        pg_q;
  logic [API_BITS-1:0]  api_q;
  logic [VSID_BITS-1:0] vsid_q;
  logic [RPN_BITS-1:0]  rpn_q;
  logic [WIMG_BITS-1:0] wimg_q;

  // Primary group outcome
  logic                p_hit_q;
  logic [RPN_BITS-1:0] p_rpn_q;
  logic [CNT_BITS-1:0] p_cnt_q;
  logic                p_free_q;

  // Result register
  logic        out_valid_q;
  logic        found_q;
  logic [31:0] mapped_q;
  logic [4:0]  removed_q;
  logic        tlb_q;
  logic        placed_q;
  logic        evicted_q;

  logic          accept;
  logic          finish;
  logic [18:0]   hash_w;
  logic [GB-1:0] pg_in;
  logic [GB-1:0] sg;
  logic          rd_en;
  logic [GB-1:0] rd_addr;
  cmp_res_t      cr;
  logic [WAYS-1:0] free_one;

  logic                v_we;
  logic [GB-1:0]       v_waddr;
  logic [WAYS-1:0]     v_wdata;
  logic                s_we;
  logic [GB-1:0]       s_waddr;
  logic [WAY_BITS-1:0] s_wway;
  entry_t              s_wdata;
  entry_t              body;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign finish     = (state_q == S_SEC) && (!out_valid_q || out_ready_i);

  // Group hash
  assign hash_w = segment_id_i[18:0] ^ {3'b000, effective_address_i[27:12]};
  assign pg_in  = hash_w[GB-1:0];
  assign sg     = ~pg_q;

  // Read primary on accept, secondary while in the primary step
  assign rd_en   = accept || (state_q == S_PRI);
  assign rd_addr = (state_q == S_PRI) ? sg : pg_in;

  hpte_cmp u_cmp (
    .valid_i (vrow_q),
    .row_i   (srow_q),
    .api_i   (api_q),
    .vsid_i  (vsid_q),
    .res_o   (cr)
  );

  assign free_one = {{(WAYS-1){1'b0}}, 1'b1} << cr.free_way;

  // Entry image for insert, protection always 0
  always_comb begin
    body      = '0;
    body.vsid = vsid_q;
    body.api  = api_q;
    body.rpn  = rpn_q;
    body.wimg = wimg_q;
  end

  // Memory write control
  always_comb begin
    v_we    = 1'b0;
    v_waddr = pg_q;
    v_wdata = '0;
    s_we    = 1'b0;
    s_waddr = pg_q;
    s_wway  = cr.free_way;
    s_wdata = body;
    case (state_q)
      S_CLR: begin
        v_we    = 1'b1;
        v_waddr = clr_cnt_q;
      end
      S_PRI: begin
        if (cmd_q == CMD_REMOVE) begin
          v_we    = 1'b1;
          v_wdata = vrow_q & ~cr.match;
        end else if (cmd_q == CMD_INSERT && cr.free) begin
          v_we    = 1'b1;
          v_wdata = vrow_q | free_one;
          s_we    = 1'b1;
        end
      end
      S_SEC: begin
        if (finish) begin
          if (cmd_q == CMD_REMOVE) begin
            v_we    = 1'b1;
            v_waddr = sg;
            v_wdata = vrow_q & ~cr.match;
          end else if (cmd_q == CMD_INSERT && !p_free_q) begin
            if (cr.free) begin
              v_we      = 1'b1;
              v_waddr   = sg;
              v_wdata   = vrow_q | free_one;
              s_we      = 1'b1;
              s_waddr   = sg;
              s_wdata.h = 1'b1;
            end else begin
              // both groups full: overwrite primary way 7
              s_we   = 1'b1;
              s_wway = WAY_BITS'(WAYS - 1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Valid memory
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    if (rd_en) begin
      vrow_q <= vmem[rd_addr];
    end
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      smem[s_waddr][s_wway] <= s_wdata;
    end
    if (rd_en) begin
      srow_q <= smem[rd_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      S_CLR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: if (accept) state_d = S_PRI;
      S_PRI:  state_d = S_SEC;
      S_SEC:  if (finish) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(command_i);
      pg_q   <= pg_in;
      api_q  <= effective_address_i[27:22];
      vsid_q <= segment_id_i;
      rpn_q  <= physical_address_i[31:12];
      wimg_q <= {write_through_i, cache_disable_i, memory_coherent_i, guarded_i};
    end
  end

  // Primary group outcome
  always_ff @(posedge clk_i) begin
    if (state_q == S_PRI) begin
      p_hit_q  <= cr.hit;
      p_rpn_q  <= cr.hit_rpn;
      p_cnt_q  <= cr.count;
      p_free_q <= cr.free;
    end
  end

  // Result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    logic                lk;
    logic                rm;
    logic                in;
    logic [4:0]          cnt;
    logic [RPN_BITS-1:0] rpn;
    lk  = (cmd_q == CMD_LOOKUP) && (p_hit_q || cr.hit);
    rm  = (cmd_q == CMD_REMOVE);
    in  = (cmd_q == CMD_INSERT) && !p_free_q;
    cnt = rm ? ({1'b0, p_cnt_q} + {1'b0, cr.count}) : 5'd0;
    rpn = p_hit_q ? p_rpn_q : cr.hit_rpn;
    if (finish) begin
      found_q   <= lk;
      mapped_q  <= lk ? {rpn, 12'h000} : 32'h0;
      removed_q <= cnt;
      tlb_q     <= (cnt != 5'd0);
      placed_q  <= in && cr.free;
      evicted_q <= in && !cr.free;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign found_o            = found_q;
  assign mapped_address_o   = mapped_q;
  assign removed_count_o    = removed_q;
  assign tlb_invalidate_o   = tlb_q;
  assign placed_secondary_o = placed_q;
  assign evicted_o          = evicted_q;

endmodule

/* rtl/hpte_checker.sv */
// Port-level checker for the hashed page table engine, bound to the top level.
module hpte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        found_o,
  input logic [31:0] mapped_address_o,
  input logic [4:0]  removed_count_o,
  input logic        tlb_invalidate_o,
  input logic        placed_secondary_o,
  input logic        evicted_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mapped_address_o)
      && $stable(removed_count_o) && $stable(found_o))
    else $error("result beat changed while stalled");

  // flush request follows the removal count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tlb_invalidate_o == (removed_count_o != 5'd0)))
    else $error("tlb_invalidate does not match removed_count");

  // lookup hit excludes remove and insert results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> (removed_count_o == 5'd0) && !placed_secondary_o
      && !evicted_o && (mapped_address_o[11:0] == 12'h000))
    else $error("lookup hit mixed with other results");

  // miss yields address 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (mapped_address_o == 32'h0))
    else $error("mapped address nonzero on miss");

  // insert places at most one way, remove clears at most 16 entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(placed_secondary_o && evicted_o) && (removed_count_o <= 5'd16))
    else $error("inconsistent insert or remove result");

endmodule

bind hashed_page_table_engine_core hpte_checker u_hpte_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .found_o            (found_o),
  .mapped_address_o   (mapped_address_o),
  .removed_count_o    (removed_count_o),
  .tlb_invalidate_o   (tlb_invalidate_o),
  .placed_secondary_o (placed_secondary_o),
  .evicted_o          (evicted_o)
);
